// ===== rtl/core/lis_pkg.sv =====
// types and constants shared by the longest increasing subsequence blocks
`default_nettype none

package lis_pkg;

    // request entries held between the front and back parts
    localparam int QUEUE_DEPTH = 2;

    localparam int VALUE_W = 32;
    localparam int INDEX_W = 10;
    localparam int LENGTH_W = 11;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      start_req;
    } in_t;

    typedef struct packed {
        logic [INDEX_W-1:0]  element_index;
        logic [LENGTH_W-1:0] chain_length;
        logic [INDEX_W-1:0]  predecessor_index;
        logic                has_predecessor;
        logic [LENGTH_W-1:0] total_length;
        logic                overflow;
    } out_t;

    // classified request handed to the back part
    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      restart;
    } cmd_t;

endpackage : lis_pkg

`default_nettype wire

// ===== rtl/core/longest_increasing_subsequence.sv =====
// top level of the streaming longest increasing subsequence tracker
//
//  channel  ports                       payload           direction
//  s_       s_valid s_ready s_data      lis_pkg::in_t     request in
//  m_       m_valid m_ready m_data      lis_pkg::out_t    result out
//
// in the back part, a request runs a binary search over the tails held so far,
// with 1023 tails searched at most; the search loop reads each tail memory once a cycle
// a request past MAX_N is dropped and answered with the overflow flag set
// aresetn is synchronous, active low; it clears the counts, the tail memories are not cleared
// a two-entry queue parts the front from the back; results wait in an output register
`default_nettype none

module longest_increasing_subsequence #(
    parameter int MAX_N = 1024
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire lis_pkg::in_t  s_data,
    output logic               m_valid,
    input  wire logic          m_ready,
    output lis_pkg::out_t      m_data
);

    logic          fr_valid;
    logic          fr_ready;
    lis_pkg::cmd_t fr_data;
    logic          q_valid;
    logic          q_ready;
    lis_pkg::cmd_t q_data;

    lis_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .cmd_valid (fr_valid),
        .cmd_ready (fr_ready),
        .cmd_data  (fr_data)
    );

    lis_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (fr_valid),
        .wr_ready (fr_ready),
        .wr_data  (fr_data),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_data  (q_data)
    );

    lis_back #(
        .MAX_N (MAX_N)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (q_valid),
        .cmd_ready (q_ready),
        .cmd_data  (q_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule : longest_increasing_subsequence

`default_nettype wire

// ===== rtl/core/lis_front.sv =====
// front part: takes requests and turns them into commands for the queue
`default_nettype none

module lis_front (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire lis_pkg::in_t  s_data,
    output logic               cmd_valid,
    input  wire logic          cmd_ready,
    output lis_pkg::cmd_t      cmd_data
);

    logic          valid_reg;
    logic          valid_next;
    lis_pkg::cmd_t cmd_reg;
    lis_pkg::cmd_t cmd_next;

    assign s_ready   = !valid_reg || cmd_ready;
    assign cmd_valid = valid_reg;
    assign cmd_data  = cmd_reg;

    always_comb begin
        valid_next = valid_reg;
        cmd_next   = cmd_reg;
        if (valid_reg && cmd_ready) begin
            valid_next = 1'b0;
        end
        if (s_valid && s_ready) begin
            valid_next       = 1'b1;
            cmd_next.value   = s_data.value;
            cmd_next.restart = s_data.start_req;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        cmd_reg <= cmd_next;
    end

endmodule : lis_front

`default_nettype wire

// ===== rtl/core/lis_queue.sv =====
// short command queue between the front and back parts
`default_nettype none

module lis_queue (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          wr_valid,
    output logic               wr_ready,
    input  wire lis_pkg::cmd_t wr_data,
    output logic               rd_valid,
    input  wire logic          rd_ready,
    output lis_pkg::cmd_t      rd_data
);

    localparam int PTR_W = $clog2(lis_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(lis_pkg::QUEUE_DEPTH + 1);

    lis_pkg::cmd_t          slot_reg [lis_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg;
    logic [PTR_W-1:0]       wr_ptr_next;
    logic [PTR_W-1:0]       rd_ptr_reg;
    logic [PTR_W-1:0]       rd_ptr_next;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;
    logic                   push;
    logic                   pop;

    assign wr_ready = (count_reg != CNT_W'(lis_pkg::QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = slot_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push) begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule : lis_queue

`default_nettype wire

// ===== rtl/core/lis_back.sv =====
// back part: binary search over the tail table, table update and result register
`default_nettype none

module lis_back #(
    parameter int MAX_N = 1024
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          cmd_valid,
    output logic               cmd_ready,
    input  wire lis_pkg::cmd_t cmd_data,
    output logic               m_valid,
    input  wire logic          m_ready,
    output lis_pkg::out_t      m_data
);

    localparam int IDX_W = $clog2(MAX_N);
    localparam int CNT_W = $clog2(MAX_N + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_WRITE
    } state_t;

    // tail tables, one slot per subsequence length
    logic signed [lis_pkg::VALUE_W-1:0] tail_value_mem [MAX_N];
    logic [IDX_W-1:0]                   tail_position_mem [MAX_N];

    state_t                             state_reg;
    state_t                             state_next;
    logic signed [lis_pkg::VALUE_W-1:0] value_reg;
    logic signed [lis_pkg::VALUE_W-1:0] value_next;
    logic [CNT_W-1:0]                   best_reg;
    logic [CNT_W-1:0]                   best_next;
    logic [CNT_W-1:0]                   count_reg;
    logic [CNT_W-1:0]                   count_next;
    logic [CNT_W-1:0]                   lo_reg;
    logic [CNT_W-1:0]                   lo_next;
    logic [CNT_W-1:0]                   hi_reg;
    logic [CNT_W-1:0]                   hi_next;
    logic [CNT_W-1:0]                   mid_reg;
    logic [CNT_W-1:0]                   mid_next;
    logic [IDX_W-1:0]                   pred_reg;
    logic [IDX_W-1:0]                   pred_next;
    logic                               has_reg;
    logic                               has_next;
    logic                               m_valid_reg;
    logic                               m_valid_next;
    lis_pkg::out_t                      m_data_reg;
    lis_pkg::out_t                      m_data_next;

    logic signed [lis_pkg::VALUE_W-1:0] rd_value_reg;
    logic [IDX_W-1:0]                   rd_pos_reg;
    logic                               mem_we;
    logic [IDX_W-1:0]                   wr_addr;

    logic                               out_free;
    logic [CNT_W-1:0]                   best_eff;
    logic [CNT_W-1:0]                   count_eff;
    logic                               tail_less;
    logic [CNT_W-1:0]                   lo_step;
    logic [CNT_W-1:0]                   hi_step;
    logic [31:0]                        count_wide;
    logic [31:0]                        chain_wide;
    logic [31:0]                        pred_wide;
    logic [31:0]                        total_wide;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
    assign wr_addr = lo_reg[IDX_W-1:0];

    always_comb begin
        state_next   = state_reg;
        value_next   = value_reg;
        best_next    = best_reg;
        count_next   = count_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        mid_next     = mid_reg;
        pred_next    = pred_reg;
        has_next     = has_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        cmd_ready    = 1'b0;
        mem_we       = 1'b0;
        out_free     = !m_valid_reg || m_ready;
        best_eff     = cmd_data.restart ? '0 : best_reg;
        count_eff    = cmd_data.restart ? '0 : count_reg;
        tail_less    = (rd_value_reg < value_reg);
        lo_step      = tail_less ? mid_reg + 1'b1 : lo_reg;
        hi_step      = tail_less ? hi_reg : mid_reg;
        count_wide   = 32'(count_reg);
        chain_wide   = 32'(lo_reg) + 32'd1;
        pred_wide    = 32'(pred_reg);
        total_wide   = 32'(best_reg);

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (cmd_valid && out_free) begin
                    cmd_ready  = 1'b1;
                    value_next = cmd_data.value;
                    best_next  = best_eff;
                    count_next = count_eff;
                    if (count_eff == CNT_W'(MAX_N)) begin
                        // sequence full: element dropped, table untouched
                        total_wide                    = 32'(best_eff);
                        m_valid_next                  = 1'b1;
                        m_data_next.element_index     = '0;
                        m_data_next.chain_length      = '0;
                        m_data_next.predecessor_index = '0;
                        m_data_next.has_predecessor   = 1'b0;
                        m_data_next.total_length      = total_wide[lis_pkg::LENGTH_W-1:0];
                        m_data_next.overflow          = 1'b1;
                    end else begin
                        lo_next   = '0;
                        hi_next   = best_eff;
                        mid_next  = best_eff >> 1;
                        pred_next = '0;
                        has_next  = 1'b0;
                        state_next = (best_eff == '0) ? ST_WRITE : ST_SEARCH;
                    end
                end
            end
            ST_SEARCH: begin
                // read data belongs to mid_reg; last lower tail gives the predecessor
                lo_next  = lo_step;
                hi_next  = hi_step;
                mid_next = lo_step + ((hi_step - lo_step) >> 1);
                if (tail_less) begin
                    pred_next = rd_pos_reg;
                    has_next  = 1'b1;
                end
                if (lo_step == hi_step) begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE: begin
                if (out_free) begin
                    mem_we     = 1'b1;
                    best_next  = (lo_reg == best_reg) ? best_reg + 1'b1 : best_reg;
                    count_next = count_reg + 1'b1;
                    total_wide = 32'(best_next);
                    m_valid_next                  = 1'b1;
                    m_data_next.element_index     = count_wide[lis_pkg::INDEX_W-1:0];
                    m_data_next.chain_length      = chain_wide[lis_pkg::LENGTH_W-1:0];
                    m_data_next.predecessor_index = pred_wide[lis_pkg::INDEX_W-1:0];
                    m_data_next.has_predecessor   = has_reg;
                    m_data_next.total_length      = total_wide[lis_pkg::LENGTH_W-1:0];
                    m_data_next.overflow          = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            best_reg    <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            best_reg    <= best_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        value_reg  <= value_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        mid_reg    <= mid_next;
        pred_reg   <= pred_next;
        has_reg    <= has_next;
        m_data_reg <= m_data_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            tail_value_mem[wr_addr] <= value_reg;
        end
        rd_value_reg <= tail_value_mem[mid_next[IDX_W-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            tail_position_mem[wr_addr] <= count_reg[IDX_W-1:0];
        end
        rd_pos_reg <= tail_position_mem[mid_next[IDX_W-1:0]];
    end

endmodule : lis_back

`default_nettype wire
